// ===== rtl/mbg_pkg.sv =====
// shared types and constants for the maze generator
`timescale 1ns / 1ps
package mbg_pkg;

    localparam int GRID_SIZE_DEF   = 32;
    localparam int STACK_DEPTH_DEF = 256;
    localparam logic [15:0] SEED_DEFAULT = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS    = 16'hB400;
    localparam logic [5:0]  DIM_RESET    = 6'd9;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [15:0] seed;
        logic [4:0]  start_x;
        logic [4:0]  start_y;
    } in_word_t;

    typedef struct packed {
        logic [4:0]  row_index;
        logic [31:0] row_walls;
        logic        last_row;
    } out_word_t;

    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        logic [15:0] n;
        n = s >> 1;
        if (s[0]) begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

    // r mod 3 by summing base-4 digits, since 4 is 1 mod 3
    function automatic logic [1:0] mod3(input logic [15:0] r);
        logic [4:0] s;
        logic [2:0] a;
        logic [2:0] b;
        s = '0;
        for (int k = 0; k < 8; k++) begin
            s = s + 5'(r[2*k +: 2]);
        end
        a = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        b = 3'(a[1:0]) + 3'(a[2]);
        return (b >= 3'd3) ? 2'(b - 3'd3) : b[1:0];
    endfunction

    // r mod (4-i) for i = 0..3
    function automatic logic [1:0] draw_mod(input logic [15:0] r, input logic [1:0] i);
        logic [1:0] m;
        unique case (i)
            2'd0: m = r[1:0];
            2'd1: m = mod3(r);
            2'd2: m = {1'b0, r[0]};
            default: m = 2'd0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/maze_backtracker_generator.sv =====
// top level of the recursive backtracker maze generator
`timescale 1ns / 1ps
// maze generator: a request word (seed, start cell) is taken only while idle.
// the block first sweeps the row store to full walls and clears the visited
// marks, one row a cycle, then walks the grid depth first: each visit of a
// cell runs the direction shuffle (one lfsr draw per cycle), then tries the
// shuffled directions one per cycle, and a backtrack passes through ST_POP
// and ST_POPW for the registered stack memory read. afterwards one row word
// per grid row is sent on the m_ channel, last_row marking the final one.
// grid_width and grid_height are written through cfg_*; the user must write
// them only while idle, which the block itself does not enforce; values
// above the grid limit saturate.
module maze_backtracker_generator #(
    parameter int GRID_SIZE   = mbg_pkg::GRID_SIZE_DEF,
    parameter int STACK_DEPTH = mbg_pkg::STACK_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mbg_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mbg_pkg::out_word_t  m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [5:0]          cfg_data
);
    localparam int LIM = (GRID_SIZE < 32) ? GRID_SIZE : 32;
    localparam int SAW = $clog2(STACK_DEPTH);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CLEAR = 8'b0000_0010,
        ST_SHUF  = 8'b0000_0100,
        ST_TRY   = 8'b0000_1000,
        ST_POP   = 8'b0001_0000,
        ST_POPW  = 8'b0010_0000,
        ST_EMIT  = 8'b0100_0000,
        ST_OPEN  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0]  cfg_w_reg, cfg_h_reg;
    logic [5:0]  w_reg, h_reg;
    logic [31:0] mask_reg;
    logic [31:0] wall_reg [32];
    logic [31:0] vis_reg  [32];
    logic [15:0] rnd_reg;
    logic [4:0]  cx_reg, cy_reg;
    logic [SAW:0] lvl_reg;
    logic [1:0]  dirs_reg [4];
    logic [1:0]  idx_reg;          // shuffle draw or direction under test
    logic [4:0]  row_reg;
    logic        out_valid_reg;
    mbg_pkg::out_word_t out_reg;

    logic [9:0]  stk_rd;

    // effective dims, saturated
    logic [5:0] w_eff, h_eff;
    assign w_eff = (cfg_w_reg > 6'(LIM)) ? 6'(LIM) : cfg_w_reg;
    assign h_eff = (cfg_h_reg > 6'(LIM)) ? 6'(LIM) : cfg_h_reg;

    // candidate neighbor for the direction under test
    logic [1:0] dsel;
    logic [6:0] nx, ny;
    logic       cand_ok;
    assign dsel = dirs_reg[idx_reg];
    always_comb begin
        nx = {2'b0, cx_reg};
        ny = {2'b0, cy_reg};
        unique case (dsel)
            2'd0: ny = ny - 7'd2;
            2'd1: nx = nx + 7'd2;
            2'd2: ny = ny + 7'd2;
            default: nx = nx - 7'd2;
        endcase
        // negative wraps to large and fails the upper bound
        cand_ok = (nx != 7'd0) && (nx < 7'({1'b0, w_reg} - 7'd1)) &&
                  (ny != 7'd0) && (ny < 7'({1'b0, h_reg} - 7'd1)) &&
                  !vis_reg[ny[4:0]][nx[4:0]];
    end
    logic [4:0] mx, my;
    assign mx = 5'((nx + {2'b0, cx_reg}) >> 1);
    assign my = 5'((ny + {2'b0, cy_reg}) >> 1);
    logic stack_full;
    assign stack_full = (lvl_reg == (SAW+1)'(STACK_DEPTH));

    logic [15:0] rnd_new;
    logic [1:0]  jdx;
    assign rnd_new = mbg_pkg::lfsr_next(rnd_reg);
    assign jdx = idx_reg + mbg_pkg::draw_mod(rnd_new, idx_reg);

    logic push;
    assign push = (state_reg == ST_TRY) && !stack_full && cand_ok;

    // output register takes the next row word
    logic emit_load;
    assign emit_load = (state_reg == ST_EMIT) && (h_reg != 6'd0) &&
                       (!out_valid_reg || m_ready);

    mbg_stack #(.DEPTH(STACK_DEPTH), .AW(SAW)) u_stack (
        .aclk    (aclk),
        .wr_en   (push),
        .wr_addr (lvl_reg[SAW-1:0]),
        .wr_data ({cy_reg, cx_reg}),
        .rd_addr (SAW'(lvl_reg - 1'b1)),
        .rd_data (stk_rd)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg <= mbg_pkg::DIM_RESET;
            cfg_h_reg <= mbg_pkg::DIM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mbg_pkg::CFG_WIDTH:  cfg_w_reg <= cfg_data;
                default:             cfg_h_reg <= cfg_data;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_CLEAR;
            ST_CLEAR: if (row_reg == 5'd31) state_next = ST_OPEN;
            ST_OPEN:  state_next = ({1'b0, cx_reg} < w_reg && {1'b0, cy_reg} < h_reg)
                                   ? ST_SHUF : ST_EMIT;
            ST_SHUF:  if (idx_reg == 2'd3) state_next = ST_TRY;
            ST_TRY: begin
                if (stack_full || !cand_ok) begin
                    if (stack_full || idx_reg == 2'd3) state_next = ST_POP;
                end else begin
                    state_next = ST_SHUF;
                end
            end
            ST_POP:   state_next = (lvl_reg == '0) ? ST_EMIT : ST_POPW;
            ST_POPW:  state_next = ST_SHUF;
            ST_EMIT: begin
                if (h_reg == 6'd0) state_next = ST_IDLE;
                else if ((!out_valid_reg || m_ready) &&
                         ({1'b0, row_reg} + 6'd1 == h_reg)) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            lvl_reg       <= '0;
            idx_reg       <= 2'd0;
            row_reg       <= 5'd0;
            rnd_reg       <= mbg_pkg::SEED_DEFAULT;
            cx_reg        <= 5'd0;
            cy_reg        <= 5'd0;
        end else begin
            state_reg <= state_next;
            if (emit_load) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (s_valid) begin
                    rnd_reg  <= (s_data.seed == 16'd0) ? mbg_pkg::SEED_DEFAULT
                                                       : s_data.seed;
                    cx_reg   <= s_data.start_x;
                    cy_reg   <= s_data.start_y;
                    lvl_reg  <= '0;
                    row_reg  <= 5'd0;
                    idx_reg  <= 2'd0;
                    w_reg    <= w_eff;
                    h_reg    <= h_eff;
                    mask_reg <= 32'((33'd1 << w_eff) - 33'd1);
                end
                ST_CLEAR: begin
                    wall_reg[row_reg] <= mask_reg;
                    vis_reg[row_reg]  <= 32'd0;
                    row_reg <= row_reg + 5'd1;
                end
                ST_OPEN: begin
                    if ({1'b0, cx_reg} < w_reg && {1'b0, cy_reg} < h_reg) begin
                        vis_reg[cy_reg][cx_reg]  <= 1'b1;
                        wall_reg[cy_reg][cx_reg] <= 1'b0;
                        dirs_reg[0] <= 2'd0; dirs_reg[1] <= 2'd1;
                        dirs_reg[2] <= 2'd2; dirs_reg[3] <= 2'd3;
                    end
                    idx_reg <= 2'd0;
                end
                ST_SHUF: begin
                    // one fisher-yates draw per cycle
                    rnd_reg <= rnd_new;
                    if (jdx != idx_reg) begin
                        dirs_reg[idx_reg] <= dirs_reg[jdx];
                        dirs_reg[jdx]     <= dirs_reg[idx_reg];
                    end
                    idx_reg <= idx_reg + 2'd1;
                end
                ST_TRY: begin
                    if (push) begin
                        wall_reg[my][mx] <= 1'b0;
                        wall_reg[ny[4:0]][nx[4:0]] <= 1'b0;
                        vis_reg[ny[4:0]][nx[4:0]]  <= 1'b1;
                        lvl_reg <= lvl_reg + 1'b1;
                        cx_reg  <= nx[4:0];
                        cy_reg  <= ny[4:0];
                        idx_reg <= 2'd0;
                        dirs_reg[0] <= 2'd0; dirs_reg[1] <= 2'd1;
                        dirs_reg[2] <= 2'd2; dirs_reg[3] <= 2'd3;
                    end else begin
                        idx_reg <= idx_reg + 2'd1;
                    end
                end
                ST_POP: begin
                    row_reg <= 5'd0;
                    if (lvl_reg != '0) lvl_reg <= lvl_reg - 1'b1;
                end
                ST_POPW: begin
                    // stack read data valid now
                    cx_reg  <= stk_rd[4:0];
                    cy_reg  <= stk_rd[9:5];
                    idx_reg <= 2'd0;
                    dirs_reg[0] <= 2'd0; dirs_reg[1] <= 2'd1;
                    dirs_reg[2] <= 2'd2; dirs_reg[3] <= 2'd3;
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        out_reg.row_index   <= row_reg;
                        out_reg.row_walls   <= wall_reg[row_reg] & mask_reg;
                        out_reg.last_row    <= ({1'b0, row_reg} + 6'd1 == h_reg);
                        row_reg <= row_reg + 5'd1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== rtl/mbg_stack.sv =====
// path stack memory with registered read
`timescale 1ns / 1ps
module mbg_stack #(
    parameter int DEPTH = mbg_pkg::STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [9:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [9:0]    rd_data
);
    logic [9:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
